[sv/vsp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vsp_pkg
// Types and constants shared by the vertex screen projection unit.
// ----------------------------------------------------------------------------
package vsp_pkg;

    localparam int SCREEN_WIDTH  = 1024;
    localparam int SCREEN_HEIGHT = 1024;

    localparam int SCREEN_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int QB         = (SCREEN_MAX > 2) ? $clog2(SCREEN_MAX) : 1;

    localparam int CW   = 50;          // clip coordinate width, signed
    localparam int DENW = CW - 1;      // positive w width
    localparam int NUMW = DENW + QB;   // dividend width

    localparam int NUM_REGS = 8;
    localparam int CFG_IW   = 8;
    localparam int CFG_DW   = 64;

    localparam logic signed [CW-1:0] W_MIN = CW'(6553);

    localparam logic signed [13:0] HALF_W = 14'(SCREEN_WIDTH / 2);
    localparam logic signed [13:0] HALF_H = 14'(SCREEN_HEIGHT / 2);
    localparam logic signed [13:0] SIZE_W = 14'(SCREEN_WIDTH);
    localparam logic signed [13:0] SIZE_H = 14'(SCREEN_HEIGHT);

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_vsp_in;

    typedef struct packed {
        logic       visible;
        logic [9:0] screen_x;
        logic [9:0] screen_y;
    } t_vsp_out;

    typedef struct packed {
        logic            vis;
        logic [NUMW-1:0] num_x;
        logic [NUMW-1:0] num_y;
        logic [DENW-1:0] den;
    } t_div_in;

    typedef struct packed {
        logic          vis;
        logic [QB-1:0] quo_x;
        logic [QB-1:0] quo_y;
    } t_div_out;

endpackage
`default_nettype wire

[sv/vertex_screen_projection_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_screen_projection_unit
// Projects Q16.16 points through a 4x4 matrix onto the screen window.
//
//   channel  | signals                                      | transfer when
//   point in | start, busy, i_point                         | start && !busy
//   result   | o_result_valid, o_result                     | o_result_valid
//   config   | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data | valid && ready
//
// one point per clock; a point passes the product, sum, scale and range stages,
// one divider stage per quotient bit and the output register
// busy is always low: results leave on a strobe and cannot be held off
// reset clears the valid pipeline and the matrix registers
// ----------------------------------------------------------------------------
module vertex_screen_projection_unit
    import vsp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire t_vsp_in           i_point,
    output logic                   o_result_valid,
    output t_vsp_out               o_result,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CFG_IW-1:0] i_cfg_index,
    input  wire logic [CFG_DW-1:0] i_cfg_data
);

    logic [CFG_DW-1:0] r_cfg [NUM_REGS];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= '0;
            end
        end else if (i_cfg_valid && (i_cfg_index < CFG_IW'(NUM_REGS))) begin
            r_cfg[i_cfg_index[2:0]] <= i_cfg_data;
        end
    end

    // matrix entries for columns 0, 1 and 3
    logic signed [31:0] m [4][3];
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            m[r][0] = r_cfg[2*r][31:0];
            m[r][1] = r_cfg[2*r][63:32];
            m[r][2] = r_cfg[2*r+1][63:32];
        end
    end

    // stage 1: floored products
    logic               r1_v;
    logic signed [47:0] r1_t [3][3];
    logic signed [31:0] p    [3];
    logic signed [63:0] prod [3][3];

    always_comb begin
        p[0] = i_point.point_x;
        p[1] = i_point.point_y;
        p[2] = i_point.point_z;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                prod[r][c] = 64'(p[r]) * 64'(m[r][c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                r1_t[r][c] <= prod[r][c][63:16];
            end
        end
    end

    // stage 2: clip coordinates
    logic                 r2_v;
    logic signed [CW-1:0] r2_c [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r2_c[c] <= CW'(r1_t[0][c]) + CW'(r1_t[1][c]) + CW'(r1_t[2][c]) + CW'(m[3][c]);
        end
    end

    // stage 3: scaled numerators and limits
    logic               r3_v;
    logic               r3_wok;
    logic signed [63:0] r3_num_x;
    logic signed [63:0] r3_num_y;
    logic signed [63:0] r3_lim_x;
    logic signed [63:0] r3_lim_y;
    logic [DENW-1:0]    r3_den;
    logic signed [CW:0] sum_x;
    logic signed [CW:0] sum_y;

    assign sum_x = (CW+1)'(r2_c[2]) + (CW+1)'(r2_c[0]);
    assign sum_y = (CW+1)'(r2_c[2]) + (CW+1)'(r2_c[1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_wok   <= (r2_c[2] > W_MIN);
        r3_num_x <= 64'(sum_x) * 64'(HALF_W);
        r3_num_y <= 64'(sum_y) * 64'(HALF_H);
        r3_lim_x <= 64'(r2_c[2]) * 64'(SIZE_W);
        r3_lim_y <= 64'(r2_c[2]) * 64'(SIZE_H);
        r3_den   <= r2_c[2][DENW-1:0];
    end

    // stage 4: window tests
    logic    r4_v;
    t_div_in r4_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_d.vis   <= r3_wok && (r3_num_x > 64'sd0) && (r3_num_x < r3_lim_x)
                      && (r3_num_y > 64'sd0) && (r3_num_y < r3_lim_y);
        r4_d.num_x <= r3_num_x[NUMW-1:0];
        r4_d.num_y <= r3_num_y[NUMW-1:0];
        r4_d.den   <= r3_den;
    end

    logic     div_v;
    t_div_out div_d;

    vsp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r4_v),
        .i_data  (r4_d),
        .o_valid (div_v),
        .o_data  (div_d)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= div_v;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result.visible  <= div_d.vis;
        o_result.screen_x <= div_d.vis ? 10'(div_d.quo_x) : 10'd0;
        o_result.screen_y <= div_d.vis ? 10'(div_d.quo_y) : 10'd0;
    end

endmodule
`default_nettype wire

[sv/vsp_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vsp_div
// Pipelined restoring divider, one quotient bit per stage, x and y sharing w.
// ----------------------------------------------------------------------------
module vsp_div
    import vsp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_div_in  i_data,
    output logic          o_valid,
    output t_div_out      o_data
);

    logic            r_v   [QB];
    logic            r_vis [QB];
    logic [NUMW-1:0] r_rx  [QB];
    logic [NUMW-1:0] r_ry  [QB];
    logic [DENW-1:0] r_den [QB];
    logic [QB-1:0]   r_qx  [QB];
    logic [QB-1:0]   r_qy  [QB];

    genvar s;
    generate
        for (s = 0; s < QB; s++) begin : g_stage
            logic            src_v;
            logic            src_vis;
            logic [NUMW-1:0] src_rx;
            logic [NUMW-1:0] src_ry;
            logic [DENW-1:0] src_den;
            logic [QB-1:0]   src_qx;
            logic [QB-1:0]   src_qy;
            logic [NUMW-1:0] sh;
            logic            gx;
            logic            gy;

            if (s == 0) begin : g_first
                assign src_v   = i_valid;
                assign src_vis = i_data.vis;
                assign src_rx  = i_data.num_x;
                assign src_ry  = i_data.num_y;
                assign src_den = i_data.den;
                assign src_qx  = '0;
                assign src_qy  = '0;
            end else begin : g_next
                assign src_v   = r_v[s-1];
                assign src_vis = r_vis[s-1];
                assign src_rx  = r_rx[s-1];
                assign src_ry  = r_ry[s-1];
                assign src_den = r_den[s-1];
                assign src_qx  = r_qx[s-1];
                assign src_qy  = r_qy[s-1];
            end

            assign sh = NUMW'(src_den) << (QB - 1 - s);
            assign gx = (src_rx >= sh);
            assign gy = (src_ry >= sh);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[s] <= 1'b0;
                end else begin
                    r_v[s] <= src_v;
                end
            end

            always_ff @(posedge i_clk) begin
                r_vis[s] <= src_vis;
                r_den[s] <= src_den;
                r_rx[s]  <= gx ? (src_rx - sh) : src_rx;
                r_ry[s]  <= gy ? (src_ry - sh) : src_ry;
                r_qx[s]  <= src_qx | (QB'(gx) << (QB - 1 - s));
                r_qy[s]  <= src_qy | (QB'(gy) << (QB - 1 - s));
            end
        end
    endgenerate

    assign o_valid      = r_v[QB-1];
    assign o_data.vis   = r_vis[QB-1];
    assign o_data.quo_x = r_qx[QB-1];
    assign o_data.quo_y = r_qy[QB-1];

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex screen projection unit testbench
// Drives points and matrix writes into the unit with random gaps, predicts
// every projection from its own copy of the matrix and checks each result
// strobe in order against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import vsp_pkg::*;

    localparam int LATENCY   = QB + 5;
    localparam int WDOG_MAX  = 5000;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;

    typedef enum int {
        ROW0_COLS01 = 0, ROW0_COLS23 = 1, ROW1_COLS01 = 2, ROW1_COLS23 = 3,
        ROW2_COLS01 = 4, ROW2_COLS23 = 5, ROW3_COLS01 = 6, ROW3_COLS23 = 7
    } t_reg_idx;

    class projection_scoreboard;
        logic [63:0] matrix_regs[NUM_REGS];
        t_vsp_out    expected_q[$];
        int          errors;

        function new();
            foreach (matrix_regs[i]) matrix_regs[i] = '0;
            errors = 0;
        endfunction

        function void set_reg(int idx, logic [63:0] value);
            if (idx >= 0 && idx < NUM_REGS) matrix_regs[idx] = value;
        endfunction

        function longint entry(int r, int c);
            logic [63:0] rg;
            rg = matrix_regs[r * 2 + c / 2];
            return (c % 2) ? longint'($signed(rg[63:32])) : longint'($signed(rg[31:0]));
        endfunction

        function longint clip(longint pv[3], int col);
            longint s;
            s = 0;
            for (int r = 0; r < 3; r++) s += (pv[r] * entry(r, col)) >>> 16;
            return s + entry(3, col);
        endfunction

        function bit to_screen(longint c, longint w, longint size, output longint pos);
            longint half, num;
            half = size / 2;
            num  = half * (w + c);
            pos  = 0;
            if (num <= 0 || num >= size * w) return 0;
            pos = num / w;
            return 1;
        endfunction

        function t_vsp_out project(t_vsp_in p);
            longint   pv[3];
            longint   cx, cy, cw, sx, sy;
            t_vsp_out r;
            pv[0] = p.point_x;
            pv[1] = p.point_y;
            pv[2] = p.point_z;
            cx = clip(pv, 0);
            cy = clip(pv, 1);
            cw = clip(pv, 3);
            r  = '0;
            if (cw > 6553 && to_screen(cx, cw, SCREEN_WIDTH, sx)
                && to_screen(cy, cw, SCREEN_HEIGHT, sy)) begin
                r.visible  = 1'b1;
                r.screen_x = sx[9:0];
                r.screen_y = sy[9:0];
            end
            return r;
        endfunction

        function void note_point(t_vsp_in p);
            expected_q.push_back(project(p));
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(t_vsp_out got);
            t_vsp_out exp_r;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result %p", got));
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.visible !== exp_r.visible)
                report($sformatf("visible got %b exp %b", got.visible, exp_r.visible));
            if (got.screen_x !== exp_r.screen_x)
                report($sformatf("screen_x got %0d exp %0d", got.screen_x, exp_r.screen_x));
            if (got.screen_y !== exp_r.screen_y)
                report($sformatf("screen_y got %0d exp %0d", got.screen_y, exp_r.screen_y));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_vsp_in     point = '0;
    logic        res_valid;
    t_vsp_out    result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_data  = '0;

    projection_scoreboard sb = new();
    int  quiet_cycles = 0;
    bit  calm_stretch = 0;

    always #1 i_clk = ~i_clk;

    vertex_screen_projection_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .start          (start),
        .busy           (busy),
        .i_point        (point),
        .o_result_valid (res_valid),
        .o_result       (result),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always @(posedge i_clk) begin
        if (rst_n) begin
            if (res_valid) sb.check_result(result);
            if (start && !busy) sb.note_point(point);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((start && !busy) || res_valid || (cfg_valid && cfg_ready) || !rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WDOG_MAX) begin
            $display("vertex_screen_projection_unit test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function int pick_gap();
        int roll;
        if (calm_stretch) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    task send_point(t_vsp_in p);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        point <= p;
        do @(posedge i_clk); while (busy);
    endtask

    task stop_points();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    task wait_drained();
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task write_reg(int idx, logic [63:0] value);
        if (pick_gap() > 0) repeat ($urandom_range(1, 4)) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IW'(idx);
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge i_clk);
    endtask

    task send_xyz(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_vsp_in p;
        p.point_x = x;
        p.point_y = y;
        p.point_z = z;
        send_point(p);
    endtask

    function logic [31:0] small_q16(int span);
        return 32'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    function t_vsp_in random_point();
        t_vsp_in p;
        int      roll, z;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            z = $urandom_range(6000, 1 << 20);
            p.point_z = z;
            p.point_x = 32'($signed($urandom_range(0, 2 * z + z / 4)) - z - z / 8);
            p.point_y = 32'($signed($urandom_range(0, 2 * z + z / 4)) - z - z / 8);
        end else if (roll < 85) begin
            p.point_x = small_q16(1 << 18);
            p.point_y = small_q16(1 << 18);
            p.point_z = small_q16(1 << 18);
        end else begin
            p.point_x = $urandom;
            p.point_y = $urandom;
            p.point_z = $urandom;
        end
        return p;
    endfunction

    task load_projection(logic [31:0] sx, logic [31:0] sy, logic [31:0] wz,
                         logic [31:0] wt);
        write_reg(ROW0_COLS01, {32'h0, sx});
        write_reg(ROW0_COLS23, 64'h0);
        write_reg(ROW1_COLS01, {sy, 32'h0});
        write_reg(ROW1_COLS23, 64'h0);
        write_reg(ROW2_COLS01, 64'h0);
        write_reg(ROW2_COLS23, {wz, 32'h0});
        write_reg(ROW3_COLS01, 64'h0);
        write_reg(ROW3_COLS23, {wt, 32'h0});
    endtask

    task load_matrix(int kind);
        logic [63:0] v;
        for (int i = 0; i < NUM_REGS; i++) begin
            case (kind)
                0: v = {small_q16(1 << 17), small_q16(1 << 17)};
                1: v = 64'h7FFF_FFFF_7FFF_FFFF;
                2: v = 64'h8000_0000_8000_0000;
                default: v = {$urandom, $urandom};
            endcase
            write_reg(t_reg_idx'(i), v);
        end
        write_reg($urandom_range(NUM_REGS, 255), {$urandom, $urandom});
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // all-zero matrix after reset: w is 0, never visible
        send_xyz(32'h7FFF_FFFF, 32'h8000_0000, Q_ONE);
        send_xyz(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        stop_points();
        wait_drained();

        load_projection(Q_ONE, Q_ONE, Q_ONE, 32'h0);
        send_xyz(32'h0, 32'h0, Q_ONE);
        send_xyz(32'h0, 32'h0, 32'd6553);
        send_xyz(32'h0, 32'h0, 32'd6554);
        send_xyz(Q_ONE, 32'h0, Q_ONE);
        send_xyz(-Q_ONE, 32'h0, Q_ONE);
        send_xyz(Q_ONE - 32'd1, Q_ONE - 32'd1, Q_ONE);
        send_xyz(-Q_ONE + 32'd1, -Q_ONE + 32'd1, Q_ONE);
        send_xyz(32'h0, Q_ONE, Q_ONE);
        send_xyz(32'h0, -Q_ONE, Q_ONE);
        send_xyz(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_xyz(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_xyz(32'h0, 32'h0, 32'h7FFF_FFFF);
        send_xyz(32'h1, 32'hFFFF_FFFF, Q_ONE);
        send_xyz(32'hFFFF_FFFF, 32'h1, 32'h8000_0000);
        stop_points();
        wait_drained();

        // out-of-range index must leave the matrix alone
        write_reg(NUM_REGS, {$urandom, $urandom});
        write_reg(255, {$urandom, $urandom});
        send_xyz(32'h0, 32'h0, Q_ONE);
        stop_points();
        wait_drained();

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0, 3: load_projection(Q_ONE, Q_ONE, Q_ONE, 32'h0);
                1: load_projection(32'h0002_0000, 32'h0000_8000, Q_ONE, 32'h0000_4000);
                2: load_matrix(0);
                4: load_matrix(1);
                5: load_matrix(2);
                default: load_matrix(3);
            endcase
            for (int n = 0; n < 185; n++) begin
                if (n % 50 == 0) calm_stretch = ($urandom_range(0, 2) == 0);
                if (n == 90) begin
                    stop_points();
                    wait_drained();
                end
                send_point(random_point());
            end
            calm_stretch = 0;
            stop_points();
            wait_drained();
        end

        repeat (2 * LATENCY) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("vertex_screen_projection_unit test passed");
        end else begin
            $display("vertex_screen_projection_unit test failed");
        end
        $finish;
    end
endmodule
